// ----- design/cpdeg_pkg.sv -----
// shared types, constants and the gate function of the chunk peak dual envelope gate
// no dependencies; imported by every module of the block
package cpdeg_pkg;

    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 15;
    localparam int ENV_W    = 23;
    localparam int COEFF_W  = 16;
    localparam int SCALE_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [PEAK_W-1:0]  PEAK_MAX     = 15'h7FFF;
    localparam logic [ENV_W-1:0]   GATE_OFFSET  = 23'd1049;
    localparam logic [COEFF_W-1:0] ATTACK_RESET = 16'd8000;
    localparam logic [COEFF_W-1:0] HISS_RESET   = 16'd300;
    localparam logic [COEFF_W-1:0] HUM_RESET    = 16'd110;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK   = 2'd0,
        CFG_HISS_REL = 2'd1,
        CFG_HUM_REL  = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_left;
        logic signed [SAMPLE_W-1:0] sample_right;
        logic                       chunk_last;
    } t_in_item;

    typedef struct packed {
        logic [SCALE_W-1:0] hiss_scale;
        logic [SCALE_W-1:0] hum_scale;
    } t_out_item;

    // clamp(4*env - 0.004, 0, 1) in Q0.16
    function automatic logic [SCALE_W-1:0] f_gate(input logic [ENV_W-1:0] env);
        logic [ENV_W:0] x;
        x = {1'b0, env} - {1'b0, GATE_OFFSET} + 24'd2;
        if (env <= GATE_OFFSET) begin
            return '0;
        end else if (|x[ENV_W:SCALE_W+2]) begin
            return '1;
        end else begin
            return x[SCALE_W+1:2];
        end
    endfunction

endpackage

// ----- design/cpdeg_mag_lane.sv -----
// magnitude lane: saturated absolute value of one Q3.12 sample
// depends on cpdeg_pkg
module cpdeg_mag_lane (
    input  logic signed [cpdeg_pkg::SAMPLE_W-1:0] i_sample,
    output logic        [cpdeg_pkg::PEAK_W-1:0]   o_mag
);
    import cpdeg_pkg::*;

    logic [SAMPLE_W-1:0] neg;

    assign neg = SAMPLE_W'(~i_sample + 1'b1);

    always_comb begin
        if (i_sample == 16'sh8000) begin
            o_mag = PEAK_MAX;
        end else if (i_sample[SAMPLE_W-1]) begin
            o_mag = neg[PEAK_W-1:0];
        end else begin
            o_mag = i_sample[PEAK_W-1:0];
        end
    end

endmodule

// ----- design/cpdeg_env_lane.sv -----
// envelope lane: one-pole attack/release follower driven by the chunk peak
// depends on cpdeg_pkg
module cpdeg_env_lane (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_load,
    input  logic [cpdeg_pkg::PEAK_W-1:0]   i_peak,
    input  logic [cpdeg_pkg::COEFF_W-1:0]  i_attack,
    input  logic [cpdeg_pkg::COEFF_W-1:0]  i_release,
    output logic [cpdeg_pkg::ENV_W-1:0]    o_env
);
    import cpdeg_pkg::*;

    localparam int PROD_W = COEFF_W + ENV_W;

    logic [ENV_W-1:0]   r_env;
    logic [ENV_W-1:0]   n_env;
    logic [ENV_W-1:0]   peak20;
    logic               rising;
    logic [ENV_W-1:0]   diff;
    logic [COEFF_W-1:0] coeff;
    logic [PROD_W-1:0]  prod;
    logic [ENV_W-1:0]   step;

    assign peak20 = {i_peak, 8'd0};
    assign rising = peak20 > r_env;
    assign diff   = rising ? (peak20 - r_env) : (r_env - peak20);
    assign coeff  = rising ? i_attack : i_release;
    assign prod   = PROD_W'(coeff) * PROD_W'(diff) + PROD_W'(32768);
    assign step   = prod[PROD_W-1:COEFF_W];
    assign n_env  = rising ? (r_env + step) : (r_env - step);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env <= '0;
        end else if (i_load) begin
            r_env <= n_env;
        end
    end

    assign o_env = r_env;

endmodule

// ----- design/chunk_peak_dual_envelope_gate_unit.sv -----
// top level of the chunk peak dual envelope gate: peak lanes, envelope lanes, output stage
// depends on cpdeg_pkg, cpdeg_mag_lane and cpdeg_env_lane
//
// channel  direction  handshake                     payload
// in       to block   i_in_valid / o_in_stall       i_in_data   (t_in_item)
// out      from block o_out_valid / i_out_stall     o_out_data  (t_out_item)
// cfg      to block   i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// one sample pair per cycle while not stalled; peak lanes and max merge are combinational
// a chunk-last transfer loads r_a_peak and clears r_peak; its result then goes through
// envelope update (one 16x23 multiply per lane), then gate into the output register
// synchronous active-low reset clears peak, envelopes and valid flags, reloads coefficients
// each stage holds while the one after it is full and stalled; o_in_stall follows that chain
module chunk_peak_dual_envelope_gate_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  cpdeg_pkg::t_in_item               i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output cpdeg_pkg::t_out_item              o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cpdeg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cpdeg_pkg::COEFF_W-1:0]     i_cfg_data
);
    import cpdeg_pkg::*;

    logic [COEFF_W-1:0] r_attack;
    logic [COEFF_W-1:0] r_hiss_rel;
    logic [COEFF_W-1:0] r_hum_rel;

    logic [PEAK_W-1:0]  r_peak;
    logic [PEAK_W-1:0]  r_a_peak;
    logic               r_a_valid;
    logic               r_b_valid;
    logic               r_out_valid;
    t_out_item          r_out_data;

    logic [PEAK_W-1:0]  mag_left;
    logic [PEAK_W-1:0]  mag_right;
    logic [PEAK_W-1:0]  lane_max;
    logic [PEAK_W-1:0]  peak_now;
    logic [ENV_W-1:0]   hiss_env;
    logic [ENV_W-1:0]   hum_env;

    logic out_free;
    logic b_free;
    logic a_free;
    logic a_move;
    logic b_move;
    logic in_xfer;

    // config writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack   <= ATTACK_RESET;
            r_hiss_rel <= HISS_RESET;
            r_hum_rel  <= HUM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ATTACK:   r_attack   <= i_cfg_data;
                CFG_HISS_REL: r_hiss_rel <= i_cfg_data;
                CFG_HUM_REL:  r_hum_rel  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline flow
    assign out_free   = !r_out_valid || !i_out_stall;
    assign b_free     = !r_b_valid || out_free;
    assign b_move     = r_b_valid && out_free;
    assign a_free     = !r_a_valid || b_free;
    assign a_move     = r_a_valid && b_free;
    assign o_in_stall = !a_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    // peak lanes and merge
    cpdeg_mag_lane u_mag_left (
        .i_sample (i_in_data.sample_left),
        .o_mag    (mag_left)
    );

    cpdeg_mag_lane u_mag_right (
        .i_sample (i_in_data.sample_right),
        .o_mag    (mag_right)
    );

    assign lane_max = (mag_left > mag_right) ? mag_left : mag_right;
    assign peak_now = (lane_max > r_peak) ? lane_max : r_peak;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak    <= '0;
            r_a_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_peak <= i_in_data.chunk_last ? '0 : peak_now;
            end
            if (in_xfer && i_in_data.chunk_last) begin
                r_a_valid <= 1'b1;
            end else if (a_move) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_in_data.chunk_last) begin
            r_a_peak <= peak_now;
        end
    end

    // envelope lanes
    cpdeg_env_lane u_env_hiss (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (a_move),
        .i_peak    (r_a_peak),
        .i_attack  (r_attack),
        .i_release (r_hiss_rel),
        .o_env     (hiss_env)
    );

    cpdeg_env_lane u_env_hum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (a_move),
        .i_peak    (r_a_peak),
        .i_attack  (r_attack),
        .i_release (r_hum_rel),
        .o_env     (hum_env)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_move) begin
            r_b_valid <= 1'b1;
        end else if (b_move) begin
            r_b_valid <= 1'b0;
        end
    end

    // gate into output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_move) begin
            r_out_data.hiss_scale <= f_gate(hiss_env);
            r_out_data.hum_scale  <= f_gate(hum_env);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // checks
    a_out_from_env: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_b_valid))
        else $error("result without envelope update");

    a_peak_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_in_data.chunk_last |=> r_peak == '0)
        else $error("peak not restarted after chunk end");

    a_env_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !a_move |=> $stable(hiss_env) && $stable(hum_env))
        else $error("envelope moved without chunk end");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_a_valid && r_b_valid && r_out_valid)
        else $error("input stalled with free stage");

endmodule
